// ===== rtl/tty_cld_pkg.sv =====
// ----------------------------------------------------------------------------
// tty_cld_pkg
// Types, codes and constants shared by the terminal line discipline.
// ----------------------------------------------------------------------------
package tty_cld_pkg;

    // Line store defaults
    localparam int unsigned LINE_DEPTH_DEF = 16;
    localparam int unsigned BYTE_W         = 8;

    // APB
    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 32;

    // Register indexes
    localparam logic [2:0] REG_IMODE = 3'd0;
    localparam logic [2:0] REG_LMODE = 3'd1;
    localparam logic [2:0] REG_OMODE = 3'd2;
    localparam logic [2:0] REG_ECHAR = 3'd3;
    localparam logic [2:0] REG_SCHAR = 3'd4;

    // Register reset values
    localparam logic [7:0]  IMODE_RST = 8'h88;
    localparam logic [5:0]  LMODE_RST = 6'h2f;
    localparam logic [2:0]  OMODE_RST = 3'h3;
    localparam logic [23:0] ECHAR_RST = 24'h020108;
    localparam logic [23:0] SCHAR_RST = 24'h1a1c03;

    // input_modes bits
    localparam int IM_ISTRIP = 0;
    localparam int IM_PARMRK = 1;
    localparam int IM_INLCR  = 2;
    localparam int IM_ICRNL  = 3;
    localparam int IM_IGNCR  = 4;
    localparam int IM_IGNPAR = 5;
    localparam int IM_IGNBRK = 6;
    localparam int IM_BRKINT = 7;

    // local_modes bits
    localparam int LM_ICANON = 0;
    localparam int LM_ECHO   = 1;
    localparam int LM_ECHOE  = 2;
    localparam int LM_ECHOK  = 3;
    localparam int LM_ECHONL = 4;
    localparam int LM_ISIG   = 5;

    // output_modes bits
    localparam int OM_OPOST = 0;
    localparam int OM_ONLCR = 1;
    localparam int OM_OCRNL = 2;

    // Input beat kinds
    localparam logic [1:0] MODE_RX    = 2'd0;
    localparam logic [1:0] MODE_BREAK = 2'd1;
    localparam logic [1:0] MODE_ERR   = 2'd2;
    localparam logic [1:0] MODE_TX    = 2'd3;

    // Result destinations
    localparam logic [1:0] DST_TX    = 2'd0;
    localparam logic [1:0] DST_QUEUE = 2'd1;
    localparam logic [1:0] DST_SIG   = 2'd2;

    // Signal codes
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd0;
    localparam logic [1:0] SIG_QUIT = 2'd1;
    localparam logic [1:0] SIG_SUSP = 2'd2;

    // Characters
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_MARK   = 8'hff;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_7BIT   = 8'h7f;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [1:0] destination;
        logic [7:0] out_byte;
        logic [1:0] signal_code;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [7:0]  input_modes;
        logic [5:0]  local_modes;
        logic [2:0]  output_modes;
        logic [23:0] edit_chars;
        logic [23:0] signal_chars;
    } cfg_t;

    // One fixed result of a beat
    typedef struct packed {
        logic [1:0] dest;
        logic [7:0] data;
        logic [1:0] sig;
    } ent_t;

    // Work plan for one input beat
    typedef struct packed {
        ent_t [2:0] fix;        // leading results, in order fix[0], fix[1], fix[2]
        logic [1:0] fix_n;
        logic       rub_one;    // one rubout echo
        logic       rub_all;    // one rubout echo per stored byte
        logic       store_en;
        logic [7:0] store_val;
        logic       full;       // store is full: flush before the write
        logic       rel_after;  // release the line after the write
        logic       cnt_dec;
        logic       cnt_clr;
    } plan_t;

    // Line store status toward the decoder
    typedef struct packed {
        logic empty;
        logic full;
    } line_stat_t;

endpackage

// ===== rtl/tty_cld_ram.sv =====
// ----------------------------------------------------------------------------
// tty_cld_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tty_cld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tty_cld_decode.sv =====
// ----------------------------------------------------------------------------
// tty_cld_decode
// Turns one input beat plus the mode registers into a work plan.
// ----------------------------------------------------------------------------
module tty_cld_decode (
    input  tty_cld_pkg::in_t       item,
    input  tty_cld_pkg::cfg_t      cfg,
    input  tty_cld_pkg::line_stat_t stat,
    output tty_cld_pkg::plan_t     plan
);
    import tty_cld_pkg::*;

    // append one fixed result
    function automatic plan_t push(input plan_t p_in, input logic [1:0] dst,
                                   input logic [7:0] b, input logic [1:0] s);
        plan_t p;
        p = p_in;
        p.fix[p.fix_n].dest = dst;
        p.fix[p.fix_n].data = b;
        p.fix[p.fix_n].sig  = s;
        p.fix_n = p.fix_n + 2'd1;
        return p;
    endfunction

    // output postprocessing of a byte headed for the transmitter
    function automatic plan_t push_tx(input plan_t p_in, input logic [7:0] b,
                                      input logic [2:0] om);
        plan_t p;
        logic [7:0] x;
        p = p_in;
        x = b;
        if (om[OM_OPOST] && om[OM_ONLCR] && b == CH_NL) begin
            p = push(p, DST_TX, CH_CR, SIG_NONE);
        end else if (om[OM_OPOST] && om[OM_OCRNL] && b == CH_CR) begin
            x = CH_NL;
        end
        p = push(p, DST_TX, x, SIG_NONE);
        return p;
    endfunction

    logic [7:0] im;
    logic [5:0] lm;
    logic [2:0] om;
    logic [7:0] erase_c, kill_c, eol_c, intr_c, quit_c, susp_c;

    assign im      = cfg.input_modes;
    assign lm      = cfg.local_modes;
    assign om      = cfg.output_modes;
    assign erase_c = cfg.edit_chars[7:0];
    assign kill_c  = cfg.edit_chars[15:8];
    assign eol_c   = cfg.edit_chars[23:16];
    assign intr_c  = cfg.signal_chars[7:0];
    assign quit_c  = cfg.signal_chars[15:8];
    assign susp_c  = cfg.signal_chars[23:16];

    always_comb begin
        plan_t      p;
        logic       rx;
        logic [7:0] c;
        logic [7:0] cc;

        p  = '0;
        rx = 1'b0;
        c  = item.data_byte;
        cc = c;

        case (item.mode)
            MODE_RX: begin
                rx = 1'b1;
            end
            MODE_BREAK: begin
                if (im[IM_IGNBRK]) begin
                    p = p;
                end else if (im[IM_BRKINT]) begin
                    p.cnt_clr = 1'b1;
                    p = push(p, DST_SIG, CH_NUL, SIG_INTR);
                end else if (im[IM_PARMRK]) begin
                    p = push(p, DST_QUEUE, CH_MARK, SIG_NONE);
                    p = push(p, DST_QUEUE, CH_NUL, SIG_NONE);
                    p = push(p, DST_QUEUE, CH_NUL, SIG_NONE);
                end else begin
                    p = push(p, DST_QUEUE, CH_NUL, SIG_NONE);
                end
            end
            MODE_ERR: begin
                if (im[IM_IGNPAR]) begin
                    rx = 1'b1;
                end else if (im[IM_PARMRK]) begin
                    p = push(p, DST_QUEUE, CH_MARK, SIG_NONE);
                    p = push(p, DST_QUEUE, CH_NUL, SIG_NONE);
                end else begin
                    p = push(p, DST_QUEUE, CH_NUL, SIG_NONE);
                end
            end
            MODE_TX: begin
                p = push_tx(p, c, om);
            end
            default: begin
                p = p;
            end
        endcase

        if (rx) begin
            if (!lm[LM_ICANON]) begin
                // raw: echo untouched, queue at once
                if (lm[LM_ECHO]) begin
                    p = push(p, DST_TX, c, SIG_NONE);
                end
                p = push(p, DST_QUEUE, c, SIG_NONE);
            end else if (!im[IM_ISTRIP] && im[IM_PARMRK] && c == CH_MARK) begin
                // escaped 0377: plain data, never a control char
                p = push(p, DST_QUEUE, CH_MARK, SIG_NONE);
                if (lm[LM_ECHO]) begin
                    p = push_tx(p, c, om);
                end
                p.store_en  = 1'b1;
                p.store_val = c;
            end else begin
                cc = im[IM_ISTRIP] ? (c & CH_7BIT) : c;
                if (im[IM_INLCR] && cc == CH_NL) begin
                    cc = CH_CR;
                end else if (im[IM_ICRNL] && cc == CH_CR) begin
                    cc = CH_NL;
                end
                if (!(im[IM_IGNCR] && cc == CH_CR)) begin
                    // echo
                    if (cc == erase_c && lm[LM_ECHOE]) begin
                        p.rub_one = !stat.empty;
                    end else if (cc == kill_c && lm[LM_ECHOK]) begin
                        p.rub_all = 1'b1;
                    end else if (lm[LM_ECHO] || (cc == CH_NL && lm[LM_ECHONL])) begin
                        p = push_tx(p, cc, om);
                    end
                    // action
                    if (cc == CH_NL || cc == eol_c) begin
                        p.store_en  = 1'b1;
                        p.store_val = cc;
                        p.rel_after = 1'b1;
                    end else if (cc == erase_c) begin
                        p.cnt_dec = !stat.empty;
                    end else if (cc == kill_c) begin
                        p.cnt_clr = 1'b1;
                    end else if (lm[LM_ISIG] && cc == quit_c) begin
                        p = push(p, DST_SIG, CH_NUL, SIG_QUIT);
                    end else if (lm[LM_ISIG] && cc == intr_c) begin
                        p = push(p, DST_SIG, CH_NUL, SIG_INTR);
                    end else if (lm[LM_ISIG] && cc == susp_c) begin
                        p = push(p, DST_SIG, CH_NUL, SIG_SUSP);
                    end else begin
                        p.store_en  = 1'b1;
                        p.store_val = cc;
                    end
                end
            end
        end

        p.full = p.store_en && stat.full;
        plan   = p;
    end

endmodule

// ===== rtl/tty_cld_seq.sv =====
// ----------------------------------------------------------------------------
// tty_cld_seq
// Plan sequencer: fixed results, rubout echoes, line store flush, write and
// release, with the line store RAM and the result register.
// ----------------------------------------------------------------------------
module tty_cld_seq #(
    parameter int unsigned LINE_DEPTH = tty_cld_pkg::LINE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  tty_cld_pkg::plan_t      plan,
    output tty_cld_pkg::line_stat_t stat,
    output logic                    m_valid,
    input  logic                    m_ready,
    output tty_cld_pkg::out_t       m_payload
);
    import tty_cld_pkg::*;

    localparam int CNT_W = $clog2(LINE_DEPTH + 1);
    localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIX   = 3'd1;
    localparam logic [2:0] ST_RUB   = 3'd2;
    localparam logic [2:0] ST_RREQ  = 3'd3;
    localparam logic [2:0] ST_REMIT = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;

    localparam logic [1:0] RUB_BS1 = 2'd0;
    localparam logic [1:0] RUB_SP  = 2'd1;
    localparam logic [1:0] RUB_BS2 = 2'd2;

    // first pending phase after the fixed results
    function automatic logic [2:0] pick(input logic rub, input logic full,
                                        input logic store);
        logic [2:0] st;
        if (rub) begin
            st = ST_RUB;
        end else if (full) begin
            st = ST_RREQ;
        end else if (store) begin
            st = ST_WRITE;
        end else begin
            st = ST_IDLE;
        end
        return st;
    endfunction

    logic [2:0]       state_reg, state_next;
    ent_t [2:0]       fix_reg, fix_next;
    logic [1:0]       fix_n_reg, fix_n_next;
    logic [1:0]       fix_idx_reg, fix_idx_next;
    logic [CNT_W-1:0] rub_left_reg, rub_left_next;
    logic [1:0]       rub_step_reg, rub_step_next;
    logic             full_pend_reg, full_pend_next;
    logic             store_pend_reg, store_pend_next;
    logic             after_pend_reg, after_pend_next;
    logic [7:0]       store_val_reg, store_val_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    logic             out_free;
    logic             emit;
    ent_t             emit_ent;
    logic             emit_last;
    logic             rub_nz;
    logic             rel_end;
    logic             ram_we, ram_re;
    logic [7:0]       ram_rdata;

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CNT_W'(LINE_DEPTH));
    assign rub_nz     = plan.rub_all ? (cnt_reg != '0) : plan.rub_one;
    assign rel_end    = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == cnt_reg;

    tty_cld_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (store_val_reg),
        .rd_en   (ram_re),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        fix_next        = fix_reg;
        fix_n_next      = fix_n_reg;
        fix_idx_next    = fix_idx_reg;
        rub_left_next   = rub_left_reg;
        rub_step_next   = rub_step_reg;
        full_pend_next  = full_pend_reg;
        store_pend_next = store_pend_reg;
        after_pend_next = after_pend_reg;
        store_val_next  = store_val_reg;
        cnt_next        = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        emit            = 1'b0;
        emit_ent        = '0;
        emit_last       = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    fix_next        = plan.fix;
                    fix_n_next      = plan.fix_n;
                    fix_idx_next    = '0;
                    rub_left_next   = plan.rub_all ? cnt_reg :
                                      (plan.rub_one ? CNT_W'(1) : '0);
                    rub_step_next   = RUB_BS1;
                    full_pend_next  = plan.full;
                    store_pend_next = plan.store_en;
                    after_pend_next = plan.rel_after;
                    store_val_next  = plan.store_val;
                    rd_idx_next     = '0;
                    if (plan.cnt_clr) begin
                        cnt_next = '0;
                    end else if (plan.cnt_dec) begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    if (plan.fix_n != 2'd0) begin
                        state_next = ST_FIX;
                    end else begin
                        state_next = pick(rub_nz, plan.full, plan.store_en);
                    end
                end
            end
            ST_FIX: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_ent  = fix_reg[fix_idx_reg];
                    emit_last = (fix_idx_reg + 2'd1 == fix_n_reg) &&
                                (rub_left_reg == '0) && !full_pend_reg && !after_pend_reg;
                    if (fix_idx_reg + 2'd1 == fix_n_reg) begin
                        fix_idx_next = '0;
                        state_next   = pick(rub_left_reg != '0, full_pend_reg,
                                            store_pend_reg);
                    end else begin
                        fix_idx_next = fix_idx_reg + 2'd1;
                    end
                end
            end
            ST_RUB: begin
                if (out_free) begin
                    emit          = 1'b1;
                    emit_ent.dest = DST_TX;
                    emit_ent.data = (rub_step_reg == RUB_SP) ? CH_SP : CH_BS;
                    emit_ent.sig  = SIG_NONE;
                    emit_last     = (rub_step_reg == RUB_BS2) &&
                                    (rub_left_reg == CNT_W'(1)) &&
                                    !full_pend_reg && !after_pend_reg;
                    if (rub_step_reg == RUB_BS2) begin
                        rub_step_next = RUB_BS1;
                        rub_left_next = rub_left_reg - CNT_W'(1);
                        if (rub_left_reg == CNT_W'(1)) begin
                            state_next = pick(1'b0, full_pend_reg, store_pend_reg);
                        end
                    end else begin
                        rub_step_next = rub_step_reg + 2'd1;
                    end
                end
            end
            ST_RREQ: begin
                ram_re     = 1'b1;
                state_next = ST_REMIT;
            end
            ST_REMIT: begin
                if (out_free) begin
                    emit          = 1'b1;
                    emit_ent.dest = DST_QUEUE;
                    emit_ent.data = ram_rdata;
                    emit_ent.sig  = SIG_NONE;
                    emit_last     = rel_end && !(full_pend_reg && after_pend_reg);
                    if (rel_end) begin
                        cnt_next    = '0;
                        rd_idx_next = '0;
                        if (full_pend_reg) begin
                            full_pend_next = 1'b0;
                            state_next     = ST_WRITE;
                        end else begin
                            after_pend_next = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end else begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = ST_RREQ;
                    end
                end
            end
            ST_WRITE: begin
                ram_we          = 1'b1;
                cnt_next        = cnt_reg + CNT_W'(1);
                store_pend_next = 1'b0;
                state_next      = after_pend_reg ? ST_RREQ : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next            = 1'b1;
            m_data_next.destination = emit_ent.dest;
            m_data_next.out_byte    = emit_ent.data;
            m_data_next.signal_code = emit_ent.sig;
            m_data_next.last        = emit_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fix_n_reg      <= '0;
            fix_idx_reg    <= '0;
            rub_left_reg   <= '0;
            rub_step_reg   <= RUB_BS1;
            full_pend_reg  <= 1'b0;
            store_pend_reg <= 1'b0;
            after_pend_reg <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fix_n_reg      <= fix_n_next;
            fix_idx_reg    <= fix_idx_next;
            rub_left_reg   <= rub_left_next;
            rub_step_reg   <= rub_step_next;
            full_pend_reg  <= full_pend_next;
            store_pend_reg <= store_pend_next;
            after_pend_reg <= after_pend_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fix_reg       <= fix_next;
        store_val_reg <= store_val_next;
        rd_idx_reg    <= rd_idx_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    // line count stays within the store
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(LINE_DEPTH))
        else $error("line count beyond store depth");

    // single port use per cycle
    a_ram_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("line store read and write in one cycle");

    // each write adds exactly one byte
    a_write_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("line count not advanced by write");

    // a new beat never lands on unfinished work
    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!full_pend_reg && !store_pend_reg &&
                                  !after_pend_reg && rub_left_reg == '0))
        else $error("beat accepted with work pending");

endmodule

// ===== rtl/tty_canonical_line_discipline_unit.sv =====
// ----------------------------------------------------------------------------
// tty_canonical_line_discipline_unit
// Serial terminal line discipline: canonical/raw input, echo, signals and
// output postprocessing, with an APB register port.
// ----------------------------------------------------------------------------
// Each input beat (received byte, break, error byte or byte to transmit)
// yields zero or more result beats on m_*, the final one flagged by last.
// One beat is worked at a time: s_ready is high while the sequencer is idle,
// even if a result still waits in the output register. A beat is accepted,
// then its fixed results (CR before NL, parity escapes, echo before a
// signal) are presented, then each rubout echo as BS, SP, BS, then any
// store flush, the store write and a line release; every released byte is
// fetched through the single registered read port of the line store RAM
// before it can be presented. A kill on a full line yields 3*LINE_DEPTH
// results. Output back pressure stalls the sequencer before each result.
// Mode registers sit at byte address 4*index and are to be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module tty_canonical_line_discipline_unit #(
    parameter int unsigned LINE_DEPTH = tty_cld_pkg::LINE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input beats
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tty_cld_pkg::in_t                    s_payload,
    // result beats
    output logic                                m_valid,
    input  logic                                m_ready,
    output tty_cld_pkg::out_t                   m_payload,
    // APB register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tty_cld_pkg::APB_AW-1:0]      paddr,
    input  logic [tty_cld_pkg::APB_DW-1:0]      pwdata,
    output logic [tty_cld_pkg::APB_DW-1:0]      prdata,
    output logic                                pready
);
    import tty_cld_pkg::*;

    logic [7:0]  imode_reg;
    logic [5:0]  lmode_reg;
    logic [2:0]  omode_reg;
    logic [23:0] echar_reg;
    logic [23:0] schar_reg;
    logic        wr_strobe;
    logic [2:0]  reg_idx;
    cfg_t        cfg;
    plan_t       plan;
    line_stat_t  stat;

    // register write happens on the access phase; pready is tied high
    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite;
    assign reg_idx   = paddr[APB_AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            imode_reg <= IMODE_RST;
            lmode_reg <= LMODE_RST;
            omode_reg <= OMODE_RST;
            echar_reg <= ECHAR_RST;
            schar_reg <= SCHAR_RST;
        end else if (wr_strobe) begin
            case (reg_idx)
                REG_IMODE: imode_reg <= pwdata[7:0];
                REG_LMODE: lmode_reg <= pwdata[5:0];
                REG_OMODE: omode_reg <= pwdata[2:0];
                REG_ECHAR: echar_reg <= pwdata[23:0];
                REG_SCHAR: schar_reg <= pwdata[23:0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IMODE: prdata = {{(APB_DW-8){1'b0}}, imode_reg};
            REG_LMODE: prdata = {{(APB_DW-6){1'b0}}, lmode_reg};
            REG_OMODE: prdata = {{(APB_DW-3){1'b0}}, omode_reg};
            REG_ECHAR: prdata = {{(APB_DW-24){1'b0}}, echar_reg};
            REG_SCHAR: prdata = {{(APB_DW-24){1'b0}}, schar_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.input_modes  = imode_reg;
    assign cfg.local_modes  = lmode_reg;
    assign cfg.output_modes = omode_reg;
    assign cfg.edit_chars   = echar_reg;
    assign cfg.signal_chars = schar_reg;

    // beat decode: translation, echo choice, line edit and signal lookup
    tty_cld_decode u_decode (
        .item (s_payload),
        .cfg  (cfg),
        .stat (stat),
        .plan (plan)
    );

    // sequencer owns the line store RAM, the line count and the result reg
    tty_cld_seq #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .plan      (plan),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ===== tb/tty_canonical_line_discipline_unit_test.sv =====
// ----------------------------------------------------------------------------
// tty_canonical_line_discipline_unit_test
// Self-checking bench for the terminal line discipline. A scoreboard model
// of the discipline predicts every result beat from each accepted input
// beat. Directed beats cover editing, signals, breaks, error bytes and the
// parity escape. Random phases then run line-shaped traffic under
// randomized and extreme mode settings, with stalls on both channels but in the last.
// ----------------------------------------------------------------------------
module tty_canonical_line_discipline_unit_test;
    import tty_cld_pkg::*;

    localparam int unsigned DEPTH         = LINE_DEPTH_DEF;
    localparam int unsigned MAX_BEATS     = 48;                 // cap per input beat
    localparam int unsigned SETTLE_CYCLES = 3 * DEPTH + 16;     // worst beat plus margin
    localparam int unsigned LIMIT_CYCLES  = 500000;

    // ------------------------------------------------------------------------
    // Clock, reset, DUT ports
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_payload = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_payload;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tty_canonical_line_discipline_unit #(
        .LINE_DEPTH (DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    in_t  pending_beats[$];     // input beats not yet put on the bus
    out_t predicted_beats[$];   // result beats still owed by the DUT
    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count  = 0;
    int unsigned fail_count     = 0;
    int unsigned setting_count  = 1;   // reset values count as one setting
    int unsigned cycle_count    = 0;
    int unsigned src_idle       = 0;
    int unsigned sink_idle      = 0;
    bit          idle_on        = 1'b1;

    // ------------------------------------------------------------------------
    // Scoreboard model: shadow copy of the mode registers and the line store
    // ------------------------------------------------------------------------
    logic [7:0]  im_q  = IMODE_RST;
    logic [5:0]  lm_q  = LMODE_RST;
    logic [2:0]  om_q  = OMODE_RST;
    logic [23:0] ech_q = ECHAR_RST;
    logic [23:0] sch_q = SCHAR_RST;
    logic [7:0]  line_buf [DEPTH];
    int unsigned line_len   = 0;
    int unsigned step_beats = 0;   // results produced by the beat being modeled

    // Queue one predicted result; anything past the per-beat cap is dropped.
    function automatic void owe_beat(logic [1:0] dst, logic [7:0] b, logic [1:0] sg);
        out_t r;
        if (step_beats >= MAX_BEATS)
            return;
        r.destination = dst;
        r.out_byte    = b;
        r.signal_code = sg;
        r.last        = 1'b0;
        predicted_beats.push_back(r);
        step_beats++;
    endfunction

    function automatic void flush_line();
        for (int i = 0; i < line_len; i++)
            owe_beat(DST_QUEUE, line_buf[i], SIG_NONE);
        line_len = 0;
    endfunction

    // A full store is released before the new byte goes in.
    function automatic void append_line(logic [7:0] c);
        if (line_len >= DEPTH)
            flush_line();
        line_buf[line_len % DEPTH] = c;
        line_len++;
    endfunction

    // Output postprocessing: NL may gain a leading CR, CR may become NL.
    function automatic void tx_path(logic [7:0] c);
        if (om_q[OM_OPOST]) begin
            if (om_q[OM_ONLCR] && c == CH_NL)
                owe_beat(DST_TX, CH_CR, SIG_NONE);
            else if (om_q[OM_OCRNL] && c == CH_CR)
                c = CH_NL;
        end
        owe_beat(DST_TX, c, SIG_NONE);
    endfunction

    function automatic void echo_rubout();
        owe_beat(DST_TX, CH_BS, SIG_NONE);
        owe_beat(DST_TX, CH_SP, SIG_NONE);
        owe_beat(DST_TX, CH_BS, SIG_NONE);
    endfunction

    function automatic void canon_rx(logic [7:0] c);
        logic [7:0] erase_ch;
        logic [7:0] kill_ch;
        logic [7:0] eol_ch;
        erase_ch = ech_q[7:0];
        kill_ch  = ech_q[15:8];
        eol_ch   = ech_q[23:16];

        // Parity-marked 0377: escape into the queue, then plain data.
        if (im_q[IM_ISTRIP]) begin
            c = c & CH_7BIT;
        end else if (im_q[IM_PARMRK] && c == CH_MARK) begin
            owe_beat(DST_QUEUE, CH_MARK, SIG_NONE);
            if (lm_q[LM_ECHO])
                tx_path(c);
            append_line(c);
            return;
        end

        if (im_q[IM_INLCR] && c == CH_NL)
            c = CH_CR;
        else if (im_q[IM_ICRNL] && c == CH_CR)
            c = CH_NL;
        if (im_q[IM_IGNCR] && c == CH_CR)
            return;

        // Echo comes first; rubout echoes bypass postprocessing.
        if (c == erase_ch && lm_q[LM_ECHOE]) begin
            if (line_len != 0)
                echo_rubout();
        end else if (c == kill_ch && lm_q[LM_ECHOK]) begin
            for (int i = 0; i < line_len; i++)
                echo_rubout();
        end else if (lm_q[LM_ECHO] || (c == CH_NL && lm_q[LM_ECHONL])) begin
            tx_path(c);
        end

        // Then the action, in priority order.
        if (c == CH_NL || c == eol_ch) begin
            append_line(c);
            flush_line();
        end else if (c == erase_ch) begin
            if (line_len != 0)
                line_len--;
        end else if (c == kill_ch) begin
            line_len = 0;
        end else if (lm_q[LM_ISIG]) begin
            if (c == sch_q[15:8])
                owe_beat(DST_SIG, CH_NUL, SIG_QUIT);
            else if (c == sch_q[7:0])
                owe_beat(DST_SIG, CH_NUL, SIG_INTR);
            else if (c == sch_q[23:16])
                owe_beat(DST_SIG, CH_NUL, SIG_SUSP);
            else
                append_line(c);
        end else begin
            append_line(c);
        end
    endfunction

    function automatic void rx_path(logic [7:0] c);
        if (lm_q[LM_ICANON]) begin
            canon_rx(c);
        end else begin
            if (lm_q[LM_ECHO])
                owe_beat(DST_TX, c, SIG_NONE);
            owe_beat(DST_QUEUE, c, SIG_NONE);
        end
    endfunction

    // Predict all results of one accepted input beat and flag the final one.
    function automatic void discipline_step(in_t it);
        out_t r;
        step_beats = 0;
        case (it.mode)
            MODE_RX: rx_path(it.data_byte);
            MODE_BREAK: begin
                if (im_q[IM_IGNBRK]) begin
                    // dropped
                end else if (im_q[IM_BRKINT]) begin
                    line_len = 0;
                    owe_beat(DST_SIG, CH_NUL, SIG_INTR);
                end else if (im_q[IM_PARMRK]) begin
                    owe_beat(DST_QUEUE, CH_MARK, SIG_NONE);
                    owe_beat(DST_QUEUE, CH_NUL, SIG_NONE);
                    owe_beat(DST_QUEUE, CH_NUL, SIG_NONE);
                end else begin
                    owe_beat(DST_QUEUE, CH_NUL, SIG_NONE);
                end
            end
            MODE_ERR: begin
                if (im_q[IM_IGNPAR]) begin
                    rx_path(it.data_byte);
                end else if (im_q[IM_PARMRK]) begin
                    owe_beat(DST_QUEUE, CH_MARK, SIG_NONE);
                    owe_beat(DST_QUEUE, CH_NUL, SIG_NONE);
                end else begin
                    owe_beat(DST_QUEUE, CH_NUL, SIG_NONE);
                end
            end
            default: tx_path(it.data_byte);
        endcase
        if (step_beats != 0) begin
            r = predicted_beats.pop_back();
            r.last = 1'b1;
            predicted_beats.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one beat held until accepted, random gaps between beats.
    // The model runs at the accepting edge, on the payload the DUT took.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            src_idle <= 0;
        end else begin
            if (s_valid && s_ready) begin
                discipline_step(s_payload);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (src_idle != 0) begin
                    s_valid  <= 1'b0;
                    src_idle <= src_idle - 1;
                end else if (pending_beats.size() != 0) begin
                    s_payload <= pending_beats.pop_front();
                    s_valid   <= 1'b1;
                    if (idle_on && $urandom_range(0, 3) == 0)
                        src_idle <= $urandom_range(1, 8);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compares each result beat with the oldest prediction and
    // throttles m_ready at random.
    // ------------------------------------------------------------------------
    out_t want_beat;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_idle <= 0;
        end else begin
            if (m_valid && m_ready) begin
                checked_count++;
                if (predicted_beats.size() == 0) begin
                    $error("unexpected result beat: dest %0d byte %02h sig %0d last %0b",
                           m_payload.destination, m_payload.out_byte,
                           m_payload.signal_code, m_payload.last);
                    fail_count++;
                end else begin
                    want_beat = predicted_beats.pop_front();
                    if (m_payload.destination !== want_beat.destination) begin
                        $error("destination: expected %0d, got %0d",
                               want_beat.destination, m_payload.destination);
                        fail_count++;
                    end
                    if (m_payload.out_byte !== want_beat.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               want_beat.out_byte, m_payload.out_byte);
                        fail_count++;
                    end
                    if (m_payload.signal_code !== want_beat.signal_code) begin
                        $error("signal_code: expected %0d, got %0d",
                               want_beat.signal_code, m_payload.signal_code);
                        fail_count++;
                    end
                    if (m_payload.last !== want_beat.last) begin
                        $error("last: expected %0b, got %0b", want_beat.last, m_payload.last);
                        fail_count++;
                    end
                end
            end
            if (sink_idle != 0) begin
                m_ready   <= 1'b0;
                sink_idle <= sink_idle - 1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready   <= 1'b0;
                sink_idle <= $urandom_range(0, 7);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_item(logic [1:0] mode, logic [7:0] b);
        in_t it;
        it.mode      = mode;
        it.data_byte = b;
        pending_beats.push_back(it);
        queued_count++;
    endfunction

    // Bytes that hit the control decoder under the current settings.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 15))
            0:       return ech_q[7:0];
            1:       return ech_q[15:8];
            2:       return ech_q[23:16];
            3:       return sch_q[7:0];
            4:       return sch_q[15:8];
            5:       return sch_q[23:16];
            6:       return CH_MARK;
            7:       return CH_CR;
            8:       return CH_NL;
            9, 10:   return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h20, 8'h7e));
        endcase
    endfunction

    // Line body: mostly printable, now and then a control byte.
    function automatic logic [7:0] line_char();
        if ($urandom_range(0, 7) == 0)
            return pick_char();
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    function automatic logic [7:0] ctrl_pick();
        case ($urandom_range(0, 11))
            0:       return CH_NUL;
            1:       return CH_BS;
            2:       return CH_7BIT;
            3:       return CH_MARK;
            4:       return ECHAR_RST[15:8];
            5:       return ECHAR_RST[23:16];
            6:       return SCHAR_RST[7:0];
            7:       return SCHAR_RST[15:8];
            8:       return SCHAR_RST[23:16];
            9:       return 8'h15;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Two-phase APB write; pready is honored though the DUT ties it high.
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Program all five mode registers and mirror them in the model.
    // Only called with both channels drained.
    task automatic set_modes(logic [7:0] im, logic [5:0] lm, logic [2:0] om,
                             logic [23:0] ec, logic [23:0] sc);
        reg_write(REG_IMODE, 32'(im));
        reg_write(REG_LMODE, 32'(lm));
        reg_write(REG_OMODE, 32'(om));
        reg_write(REG_ECHAR, 32'(ec));
        reg_write(REG_SCHAR, 32'(sc));
        im_q  = im;
        lm_q  = lm;
        om_q  = om;
        ech_q = ec;
        sch_q = sc;
        setting_count++;
    endtask

    // Sender holds off until every beat is taken and every result is in.
    // A beat with no result may still be in work, hence the settle time.
    task automatic drain();
        while (accepted_count != queued_count || predicted_beats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly whole lines (some long enough to overflow the store), mixed
    // with transmit bytes, breaks, error bytes and stray controls.
    task automatic random_phase(int unsigned n);
        int unsigned first;
        int unsigned len;
        logic [7:0]  tail;
        first = queued_count;
        while (queued_count - first < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20)
                                                      : $urandom_range(0, 8);
                    repeat (len)
                        push_item(($urandom_range(0, 11) == 0) ? MODE_ERR : MODE_RX,
                                  line_char());
                    case ($urandom_range(0, 3))
                        0:       tail = CH_CR;
                        1:       tail = ech_q[23:16];
                        default: tail = CH_NL;
                    endcase
                    push_item(MODE_RX, tail);
                end
                6:       push_item(MODE_TX, ($urandom_range(0, 1) == 0) ? pick_char()
                                                                   : 8'($urandom_range(0, 255)));
                7:       push_item(MODE_BREAK, 8'($urandom_range(0, 255)));
                8:       push_item(MODE_ERR, 8'($urandom_range(0, 255)));
                default: push_item(MODE_RX, pick_char());
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: canonical, echo, echo-erase/kill, signals,
        // CR-to-NL and break-interrupt on input, NL to CRNL on output.
        push_item(MODE_RX, 8'h61);
        push_item(MODE_RX, 8'hfe);                 // high bit kept without strip
        push_item(MODE_RX, ECHAR_RST[7:0]);        // erase with echo
        push_item(MODE_RX, 8'h62);
        push_item(MODE_RX, ECHAR_RST[15:8]);       // kill: one rubout per stored byte
        push_item(MODE_RX, ECHAR_RST[7:0]);        // erase on empty line: silent
        push_item(MODE_RX, 8'h78);
        push_item(MODE_RX, CH_CR);                 // CR -> NL, echoed CR NL, line out
        push_item(MODE_RX, SCHAR_RST[7:0]);        // interrupt
        push_item(MODE_RX, SCHAR_RST[15:8]);       // quit
        push_item(MODE_RX, SCHAR_RST[23:16]);      // suspend
        push_item(MODE_RX, 8'h71);
        push_item(MODE_BREAK, 8'h00);              // break-int drops the pending line
        push_item(MODE_RX, ECHAR_RST[23:16]);      // end-of-line char releases
        push_item(MODE_TX, CH_NL);
        push_item(MODE_TX, CH_MARK);
        drain();

        // Parity marking without strip: escaped 0377, marked break and error,
        // CR kept as data; CR to NL on output.
        set_modes(8'h02, 6'h3f, 3'h7, 24'h7f1508, SCHAR_RST);
        push_item(MODE_RX, CH_MARK);
        push_item(MODE_RX, CH_CR);
        push_item(MODE_BREAK, 8'hff);
        push_item(MODE_ERR, 8'h55);
        push_item(MODE_RX, CH_NL);
        push_item(MODE_TX, CH_CR);
        drain();

        // All ones, raw and silent: break ignored, error byte passed as data.
        set_modes(8'hff, 6'h00, 3'h0, 24'hffffff, 24'hffffff);
        push_item(MODE_BREAK, 8'h00);
        push_item(MODE_ERR, CH_MARK);
        push_item(MODE_RX, CH_NUL);
        push_item(MODE_TX, CH_NL);
        drain();

        // Zero as a control char matches; echo-newline without echo.
        set_modes(8'h00, 6'h31, 3'h3, 24'h0b0c0d, 24'h000000);
        push_item(MODE_RX, CH_NUL);                // quit (checked first)
        push_item(MODE_RX, 8'h7a);
        push_item(MODE_RX, CH_CR);                 // erase, no echo-erase
        push_item(MODE_RX, CH_NL);
        drain();

        // Random phases; phase 1 all ones, phase 2 all zeros, the last one
        // runs with no stalls on either side.
        for (int p = 0; p < 6; p++) begin
            case (p)
                1:       set_modes(8'hff, 6'h3f, 3'h7, 24'hffffff, 24'hffffff);
                2:       set_modes(8'h00, 6'h00, 3'h0, 24'h000000, 24'h000000);
                5:       set_modes(8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                                   3'($urandom_range(0, 7)),
                                   {ctrl_pick(), ctrl_pick(), ctrl_pick()},
                                   {ctrl_pick(), ctrl_pick(), ctrl_pick()});
                default: set_modes(8'($urandom_range(0, 255)),
                                   6'($urandom_range(0, 63)) | 6'h01,
                                   3'($urandom_range(0, 7)),
                                   {ctrl_pick(), ctrl_pick(), ctrl_pick()},
                                   {ctrl_pick(), ctrl_pick(), ctrl_pick()});
            endcase
            idle_on = (p != 5);
            random_phase(12);
            drain();
        end

        $display("Run covered %0d input beats under %0d mode settings, %0d result beats checked.",
                 accepted_count, setting_count, checked_count);
        $display("Mismatches found: %0d", fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: a hung handshake or a missing result ends here.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
